// ===== hw/rtl/sdf_pkg.sv =====
`default_nettype none

package sdf_pkg;

    localparam int ELEM_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int OUT_DATA_BITS = ELEM_W + SLOT_W + COUNT_W;
    localparam int TDATA_W = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int TUSER_W = 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } sdf_state_t;

    typedef struct packed {
        logic                last;
        logic                overflow;
        logic [COUNT_W-1:0]  unique_count;
        logic [SLOT_W-1:0]   slot;
        logic                kept;
        logic [ELEM_W-1:0]   element;
    } sdf_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdf_table.sv =====
`default_nettype none

module sdf_table
    import sdf_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int KEY_W = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [KEY_W-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sdf_ctrl.sv =====
`default_nettype none

module sdf_ctrl
    import sdf_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int KEY_W = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ELEM_W-1:0] in_elem,
    input  wire logic              in_last,
    input  wire logic              out_free,
    output logic                   res_valid,
    output sdf_result_t            res,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    input  wire logic [KEY_W-1:0]  rd_data,
    output logic                   wr_en,
    output logic      [AW-1:0]     wr_addr,
    output logic      [KEY_W-1:0]  wr_data
);

    sdf_state_t        state_reg, state_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     pos_reg, pos_next;

    logic              hit;
    logic              scan_end;
    logic              full;
    logic              keep;
    logic [CW-1:0]     new_cnt;

    // shared comparator: one stored unique per cycle against the held key
    assign hit      = cmp_vld_reg && (rd_data == key_reg);
    assign scan_end = cmp_vld_reg && (CW'(cmp_idx_reg) == cnt_reg - CW'(1));
    assign full     = (cnt_reg == CW'(DEPTH));
    assign keep     = !found_reg && !full;
    assign new_cnt  = keep ? cnt_reg + CW'(1) : cnt_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign rd_en    = (state_reg == S_SCAN) && (idx_reg < cnt_reg);
    assign rd_addr  = idx_reg[AW-1:0];
    assign wr_en    = (state_reg == S_DONE) && out_free && keep;
    assign wr_addr  = cnt_reg[AW-1:0];
    assign wr_data  = key_reg;

    assign res_valid        = (state_reg == S_DONE) && out_free;
    assign res.element      = elem_reg;
    assign res.kept         = keep;
    assign res.slot         = found_reg ? SLOT_W'(pos_reg)
                            : (full ? '0 : SLOT_W'(cnt_reg));
    assign res.unique_count = COUNT_W'(new_cnt);
    assign res.overflow     = !found_reg && full;
    assign res.last         = last_reg;

    always_comb
    begin
        state_next   = state_reg;
        elem_next    = elem_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    elem_next  = in_elem;
                    key_next   = in_elem[KEY_W-1:0];
                    last_next  = in_last;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (cnt_reg == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    idx_next     = idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                end
                if (hit)
                begin
                    found_next   = 1'b1;
                    pos_next     = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (scan_end)
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the item
                if (out_free)
                begin
                    cnt_next   = last_reg ? '0 : new_cnt;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg    <= elem_next;
        key_reg     <= key_next;
        last_reg    <= last_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stream_dedup_filter.sv =====
// First-occurrence duplicate filter. Elements of a vector arrive one item at a
// time, the final one marked by tlast. Each element is compared against the
// uniques stored so far for the vector; a new value goes to the next slot and
// is flagged kept, a repeat is dropped and reports the slot of its first
// copy, and a new value that finds all DEPTH slots taken is flagged overflow.
// One shared comparator walks the table one stored entry per cycle, so the
// time an item takes grows with N, the unique count before it (at most DEPTH),
// and a match ends the walk early. The block takes one item at a time; a
// finished result waits in an output register while the next item is taken
// in. The table is forgotten after the tlast item. Only the low ELEM_WIDTH
// bits of an element are compared and stored.
`default_nettype none

module stream_dedup_filter
    import sdf_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [ELEM_W-1:0]  s_axis_tdata,  // element[31:0]
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [TDATA_W-1:0] m_axis_tdata,  // element_out[31:0], slot[37:32],
                                                   // unique_count[44:38], zero pad
    output logic      [TUSER_W-1:0] m_axis_tuser,  // kept[0], overflow[1]
    output logic                    m_axis_tlast
);

    localparam int KEY_W = (ELEM_WIDTH < ELEM_W) ? ELEM_WIDTH : ELEM_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             out_free;
    logic             res_valid;
    sdf_result_t      res;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    logic             m_valid_reg, m_valid_next;
    sdf_result_t      m_res_reg, m_res_next;

    assign out_free = !m_valid_reg || m_axis_tready;

    sdf_ctrl #(
        .DEPTH (DEPTH),
        .KEY_W (KEY_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_elem   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sdf_table #(
        .DEPTH (DEPTH),
        .KEY_W (KEY_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - OUT_DATA_BITS)'(0), m_res_reg.unique_count,
                            m_res_reg.slot, m_res_reg.element};
    assign m_axis_tuser  = {m_res_reg.overflow, m_res_reg.kept};
    assign m_axis_tlast  = m_res_reg.last;

    // a new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!m_valid_reg || m_axis_tready))
        else $error("result overwrote a pending output item");

    // the block is not ready again in the cycle after it accepts an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("block ready right after accepting an item");

    a_kept_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.kept && res.overflow))
        else $error("result both kept and overflow");

    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overflow) |-> (res.unique_count == COUNT_W'(DEPTH)))
        else $error("overflow with table not full");

endmodule

`default_nettype wire
